[rtl/core/rig_pkg.sv]
// Package for the random ID generator: opcodes, constants, microcode ROM,
// the xorshift128+ draw and the nanoid alphabet.
// No dependencies.
package rig_pkg;

    localparam int MAX_NANO_LENGTH_DEF = 256;
    localparam int NANO_DEFAULT_LEN    = 21;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_B = 1'd1;

    localparam logic [63:0] ZERO_SEED_A = 64'hdeadbeefcafebabe;
    localparam logic [63:0] ZERO_SEED_B = 64'h0123456789abcdef;
    localparam logic [63:0] MIX_MUL_ONE = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_TWO = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] OP_UUID  = 2'd0;
    localparam logic [1:0] OP_SHORT = 2'd1;
    localparam logic [1:0] OP_NANO  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [3:0]        uop_t;
    typedef logic [1:0]        cond_t;

    // datapath operations
    localparam uop_t U_SEED      = 4'd0;
    localparam uop_t U_TL        = 4'd1;
    localparam uop_t U_TM        = 4'd2;
    localparam uop_t U_TH        = 4'd3;
    localparam uop_t U_CS        = 4'd4;
    localparam uop_t U_NH        = 4'd5;
    localparam uop_t U_NL        = 4'd6;
    localparam uop_t U_EMIT_UUID = 4'd7;
    localparam uop_t U_SID_DRAW  = 4'd8;
    localparam uop_t U_XS33      = 4'd9;
    localparam uop_t U_MUL_LL    = 4'd10;
    localparam uop_t U_MUL_LH    = 4'd11;
    localparam uop_t U_MUL_HL    = 4'd12;
    localparam uop_t U_EMIT_SID  = 4'd13;
    localparam uop_t U_CHAR      = 4'd14;
    localparam uop_t U_EMIT_NANO = 4'd15;

    // sequencing
    localparam cond_t C_NEXT = 2'd0;
    localparam cond_t C_END  = 2'd1;
    localparam cond_t C_CHAR = 2'd2;
    localparam cond_t C_NANO = 2'd3;

    localparam step_t ENTRY_UUID  = 5'd0;
    localparam step_t ENTRY_SHORT = 5'd9;
    localparam step_t ENTRY_NANO  = 5'd21;
    localparam step_t STEP_CHAR   = 5'd22;
    localparam step_t STEP_NONE   = 5'd0;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
        logic  last;
        logic  mul_two;
    } ucode_t;

    typedef struct packed {
        logic boundary;
        logic done;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] b;
        logic [63:0] val;
    } draw_t;

    function automatic draw_t xs_draw(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] x;
        draw_t       r;
        x     = a ^ (a << 23);
        r.b   = x ^ b ^ (x >> 17) ^ (b >> 26);
        r.val = r.b + b;
        return r;
    endfunction

    function automatic logic [7:0] nano_char(input logic [5:0] idx);
        logic [7:0] r;
        if (idx < 6'd26)
            r = 8'h41 + {2'b00, idx};
        else if (idx < 6'd52)
            r = 8'h61 + {2'b00, idx - 6'd26};
        else if (idx < 6'd62)
            r = 8'h30 + {2'b00, idx - 6'd52};
        else if (idx == 6'd62)
            r = 8'h5f;
        else
            r = 8'h2d;
        return r;
    endfunction

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            5'd0:    w = '{U_SEED,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd1:    w = '{U_TL,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd2:    w = '{U_TM,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd3:    w = '{U_TH,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd4:    w = '{U_EMIT_UUID, C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd5:    w = '{U_CS,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd6:    w = '{U_NH,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd7:    w = '{U_NL,        C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd8:    w = '{U_EMIT_UUID, C_END,  STEP_NONE, 1'b1, 1'b0};
            5'd9:    w = '{U_SEED,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd10:   w = '{U_SID_DRAW,  C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd11:   w = '{U_XS33,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd12:   w = '{U_MUL_LL,    C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd13:   w = '{U_MUL_LH,    C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd14:   w = '{U_MUL_HL,    C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd15:   w = '{U_XS33,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd16:   w = '{U_MUL_LL,    C_NEXT, STEP_NONE, 1'b0, 1'b1};
            5'd17:   w = '{U_MUL_LH,    C_NEXT, STEP_NONE, 1'b0, 1'b1};
            5'd18:   w = '{U_MUL_HL,    C_NEXT, STEP_NONE, 1'b0, 1'b1};
            5'd19:   w = '{U_XS33,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd20:   w = '{U_EMIT_SID,  C_END,  STEP_NONE, 1'b1, 1'b0};
            5'd21:   w = '{U_SEED,      C_NEXT, STEP_NONE, 1'b0, 1'b0};
            5'd22:   w = '{U_CHAR,      C_CHAR, STEP_CHAR, 1'b0, 1'b0};
            5'd23:   w = '{U_EMIT_NANO, C_NANO, STEP_CHAR, 1'b0, 1'b0};
            default: w = '{U_SEED,      C_END,  STEP_NONE, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/rig_if.sv]
// Channel interfaces of the random ID generator: request, result and
// configuration write. Depends on rig_pkg.
interface rig_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [8:0] nano_length;

    modport source (output valid, opcode, nano_length, input ready);
    modport sink   (input valid, opcode, nano_length, output ready);
endinterface

interface rig_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] id_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, id_word, byte_count, last, input ready);
    modport sink   (input valid, id_word, byte_count, last, output ready);
endinterface

interface rig_cfg_if;
    import rig_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/rig_datapath.sv]
// Datapath of the random ID generator: seed registers, xorshift128+ state,
// mixer with a shared 32x32 multiplier, word assembly and output register.
// Driven by one microcode word per step. Depends on rig_pkg.
module rig_datapath #(
    parameter int MAX_NANO_LENGTH = rig_pkg::MAX_NANO_LENGTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          start,
    input  logic [8:0]                    nano_length,
    input  logic                          fire,
    input  rig_pkg::ucode_t               ctrl,
    output rig_pkg::dp_status_t           status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [63:0]                   out_word,
    output logic [3:0]                    out_count,
    output logic                          out_last
);
    import rig_pkg::*;

    localparam int LEN_CAP = (MAX_NANO_LENGTH > NANO_DEFAULT_LEN) ?
                             MAX_NANO_LENGTH : NANO_DEFAULT_LEN;
    localparam int LEN_W   = $clog2(LEN_CAP + 1);

    logic [63:0]      seed_a_reg, seed_a_next;
    logic [63:0]      seed_b_reg, seed_b_next;
    logic [63:0]      gen_a_reg, gen_a_next;
    logic [63:0]      gen_b_reg, gen_b_next;
    logic             seeded_reg, seeded_next;
    logic [63:0]      count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic [63:0]      c_reg, c_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      word_reg, word_next;
    logic [LEN_W-1:0] chr_reg, chr_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [63:0]      out_word_reg, out_word_next;
    logic [3:0]       out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    draw_t            dr;
    logic [63:0]      count_inc;
    logic [63:0]      mul_k;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic [LEN_W-1:0] len_res;
    logic [LEN_W-1:0] chr_inc;
    logic [3:0]       nano_count;

    assign dr        = xs_draw(gen_a_reg, gen_b_reg);
    assign count_inc = count_reg + 64'd1;
    assign mul_k     = ctrl.mul_two ? MIX_MUL_TWO : MIX_MUL_ONE;
    assign mul_a     = (ctrl.uop == U_MUL_LH) ? c_reg[63:32] : c_reg[31:0];
    assign mul_b     = (ctrl.uop == U_MUL_HL) ? mul_k[63:32] : mul_k[31:0];
    assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
    assign chr_inc   = chr_reg + LEN_W'(1);
    assign nano_count = (chr_reg[2:0] == 3'd0) ? 4'd8 : {1'b0, chr_reg[2:0]};

    always_comb
    begin
        if (nano_length != 9'd0 && {1'b0, nano_length} <= 10'(MAX_NANO_LENGTH))
            len_res = LEN_W'(nano_length);
        else
            len_res = LEN_W'(NANO_DEFAULT_LEN);
    end

    assign status.boundary = (chr_reg[2:0] == 3'd7) || (chr_inc == len_reg);
    assign status.done     = (chr_reg == len_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        seed_a_next    = seed_a_reg;
        seed_b_next    = seed_b_reg;
        gen_a_next     = gen_a_reg;
        gen_b_next     = gen_b_reg;
        seeded_next    = seeded_reg;
        count_next     = count_reg;
        c_next         = c_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        chr_next       = chr_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_SEED_A)
                seed_a_next = cfg_data;
            if (cfg_index == CFG_SEED_B)
                seed_b_next = cfg_data;
        end

        if (start)
        begin
            word_next = 64'd0;
            chr_next  = '0;
            len_next  = len_res;
        end

        if (fire)
        begin
            case (ctrl.uop)
                U_SEED:
                begin
                    if (!seeded_reg)
                    begin
                        gen_a_next  = (seed_a_reg == 64'd0) ? ZERO_SEED_A : seed_a_reg;
                        gen_b_next  = (seed_b_reg == 64'd0) ? ZERO_SEED_B : seed_b_reg;
                        seeded_next = 1'b1;
                    end
                end
                U_TL, U_TM, U_TH, U_CS, U_NH, U_NL:
                begin
                    gen_a_next = gen_b_reg;
                    gen_b_next = dr.b;
                    case (ctrl.uop)
                        U_TL:    word_next[63:32] = dr.val[63:32];
                        U_TM:    word_next[31:16] = dr.val[63:48];
                        U_TH:    word_next[15:0]  = {4'h4, dr.val[63:52]};
                        U_CS:    word_next[63:48] = {2'b10, dr.val[63:50]};
                        U_NH:    word_next[47:32] = dr.val[63:48];
                        default: word_next[31:0]  = dr.val[63:32];
                    endcase
                end
                U_EMIT_UUID:
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    out_count_next = 4'd8;
                    out_last_next  = ctrl.last;
                end
                U_SID_DRAW:
                begin
                    gen_a_next = gen_b_reg;
                    gen_b_next = dr.b;
                    count_next = count_inc;
                    c_next     = dr.val ^ count_inc;
                end
                U_XS33:
                    c_next = c_reg ^ (c_reg >> 33);
                U_MUL_LL:
                    acc_next = prod;
                U_MUL_LH:
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                U_MUL_HL:
                    c_next = acc_reg + {prod[31:0], 32'd0};
                U_EMIT_SID:
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = {32'd0, c_reg[63:32]};
                    out_count_next = 4'd4;
                    out_last_next  = 1'b1;
                end
                U_CHAR:
                begin
                    gen_a_next = gen_b_reg;
                    gen_b_next = dr.b;
                    word_next[8*chr_reg[2:0] +: 8] = nano_char(dr.val[5:0]);
                    chr_next = chr_inc;
                end
                U_EMIT_NANO:
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    out_count_next = nano_count;
                    out_last_next  = (chr_reg == len_reg);
                    word_next      = 64'd0;
                end
                default:
                    c_next = c_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg    <= 64'd0;
            seed_b_reg    <= 64'd0;
            gen_a_reg     <= 64'd0;
            gen_b_reg     <= 64'd0;
            seeded_reg    <= 1'b0;
            count_reg     <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_a_reg    <= seed_a_next;
            seed_b_reg    <= seed_b_next;
            gen_a_reg     <= gen_a_next;
            gen_b_reg     <= gen_b_next;
            seeded_reg    <= seeded_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        acc_reg       <= acc_next;
        word_reg      <= word_next;
        chr_reg       <= chr_next;
        len_reg       <= len_next;
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/random_id_generator.sv]
// Random ID generator top level: microcode sequencer (step counter, ROM,
// conditional jumps) around rig_datapath. Depends on rig_pkg, rig_if.
// One request at a time. Steps: uuid 9, short id 12, nanoid of L chars
// 1 + L + ceil(L/8); one step per cycle unless an emit waits on the output
// register. The next request is taken once the final result is loaded.
// Reset clears seeds, generator, counter and sequencer; the generator
// loads from the seeds on the first request.
module random_id_generator #(
    parameter int MAX_NANO_LENGTH = rig_pkg::MAX_NANO_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rig_cfg_if.sink    cfg,
    rig_req_if.sink    req,
    rig_rsp_if.source  rsp
);
    import rig_pkg::*;

    logic       busy_reg, busy_next;
    step_t      step_reg, step_next;
    ucode_t     ctrl;
    dp_status_t status;
    logic       is_emit;
    logic       fire;
    logic       start;

    assign ctrl    = ucode_rom(step_reg);
    assign is_emit = (ctrl.uop == U_EMIT_UUID) || (ctrl.uop == U_EMIT_SID) ||
                     (ctrl.uop == U_EMIT_NANO);
    assign fire    = busy_reg && (!is_emit || status.out_free);
    assign start   = req.valid && !busy_reg && (req.opcode != OP_NONE);

    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            case (req.opcode)
                OP_UUID:  step_next = ENTRY_UUID;
                OP_SHORT: step_next = ENTRY_SHORT;
                default:  step_next = ENTRY_NANO;
            endcase
        end
        else if (fire)
        begin
            case (ctrl.cond)
                C_NEXT:  step_next = step_reg + step_t'(1);
                C_END:   busy_next = 1'b0;
                C_CHAR:  step_next = status.boundary ? step_reg + step_t'(1) : ctrl.target;
                C_NANO:
                begin
                    if (status.done)
                        busy_next = 1'b0;
                    else
                        step_next = ctrl.target;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    rig_datapath #(
        .MAX_NANO_LENGTH (MAX_NANO_LENGTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .start       (start),
        .nano_length (req.nano_length),
        .fire        (fire),
        .ctrl        (ctrl),
        .status      (status),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_word    (rsp.id_word),
        .out_count   (rsp.byte_count),
        .out_last    (rsp.last)
    );

endmodule

[rtl/core/rig_checker.sv]
// Port-level checks for random_id_generator, attached by bind.
// Depends on rig_pkg and the top level's ports.
module rig_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_opcode,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_id_word,
    input logic [3:0]  rsp_byte_count,
    input logic        rsp_last
);
    import rig_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id_word) &&
        $stable(rsp_byte_count) && $stable(rsp_last))
        else $error("result changed while stalled");

    // a real request blocks the next one
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode != OP_NONE |=> !req_ready)
        else $error("request taken while previous one in progress");

    // no new request while a request still has results to come
    a_no_req_mid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("ready high before final result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_byte_count != 4'd0 && rsp_byte_count <= 4'd8)
        else $error("byte count out of range");

    // four-byte words only end a request and have zero high bytes
    a_partial_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_byte_count == 4'd4 |-> rsp_last && rsp_id_word[63:32] == 32'd0)
        else $error("bad four-byte word");

endmodule

bind random_id_generator rig_checker u_rig_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_opcode     (req.opcode),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_id_word    (rsp.id_word),
    .rsp_byte_count (rsp.byte_count),
    .rsp_last       (rsp.last)
);

[verif/random_id_generator_test.sv]
// Self-checking testbench for random_id_generator: drives seed writes and
// uuid / short id / nanoid requests and compares every result word with a
// built-in xorshift128+ predictor. Depends on rig_pkg, rig_if and the RTL.
module random_id_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rig_pkg::*;

    localparam string NANO_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_-";
    localparam int RANDOM_REQUESTS = 360;
    localparam int SETTLE_CYCLES   = 16;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } id_result_t;

    class id_model;
        logic [63:0] seed_a;
        logic [63:0] seed_b;
        logic [63:0] gen_a;
        logic [63:0] gen_b;
        logic [63:0] short_count;
        bit          seeded;
        id_result_t  expected_ids[$];
        int          errors;

        function new();
            seed_a      = '0;
            seed_b      = '0;
            gen_a       = '0;
            gen_b       = '0;
            short_count = '0;
            seeded      = 1'b0;
            errors      = 0;
        endfunction

        function void store_seed(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == CFG_SEED_A)
                seed_a = value;
            else
                seed_b = value;
        endfunction

        function logic [63:0] draw();
            logic [63:0] x;
            logic [63:0] y;
            x     = gen_a;
            y     = gen_b;
            gen_a = y;
            x     = x ^ (x << 23);
            gen_b = x ^ y ^ (x >> 17) ^ (y >> 26);
            return gen_b + y;
        endfunction

        function void push_id(logic [63:0] word, logic [3:0] count, logic last);
            id_result_t r;
            r.word  = word;
            r.count = count;
            r.last  = last;
            expected_ids.push_back(r);
        endfunction

        function void note_request(logic [1:0] op, logic [8:0] len);
            logic [63:0] tl, tm, th, cs, nh, nl, c, d, word;
            int          n;
            int          pos;
            if (op == OP_NONE)
                return;
            if (!seeded)
            begin
                gen_a  = (seed_a == 0) ? ZERO_SEED_A : seed_a;
                gen_b  = (seed_b == 0) ? ZERO_SEED_B : seed_b;
                seeded = 1'b1;
            end
            case (op)
                OP_UUID:
                begin
                    tl = draw() >> 32;
                    tm = draw() >> 48;
                    th = 64'h4000 | ((draw() >> 52) & 64'h0fff);
                    cs = 64'h8000 | ((draw() >> 50) & 64'h3fff);
                    nh = draw() >> 48;
                    nl = draw() >> 32;
                    push_id((tl << 32) | (tm << 16) | th, 4'd8, 1'b0);
                    push_id((cs << 48) | (nh << 32) | nl, 4'd8, 1'b1);
                end
                OP_SHORT:
                begin
                    short_count = short_count + 1;
                    c = draw() ^ short_count;
                    c = c ^ (c >> 33);
                    c = c * MIX_MUL_ONE;
                    c = c ^ (c >> 33);
                    c = c * MIX_MUL_TWO;
                    c = c ^ (c >> 33);
                    push_id(c >> 32, 4'd4, 1'b1);
                end
                default:
                begin
                    n    = (len >= 1 && len <= MAX_NANO_LENGTH_DEF) ? int'(len)
                                                                    : NANO_DEFAULT_LEN;
                    word = '0;
                    for (int i = 0; i < n; i++)
                    begin
                        pos = i % 8;
                        d   = draw();
                        word[8*pos +: 8] = NANO_ALPHABET[d[5:0]];
                        if (pos == 7 || i + 1 == n)
                        begin
                            push_id(word, 4'(pos + 1), (i + 1 == n));
                            word = '0;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [63:0] word, logic [3:0] count, logic last);
            id_result_t e;
            if (expected_ids.size() == 0)
            begin
                $error("unexpected result: id_word %h byte_count %0d last %b",
                       word, count, last);
                errors++;
                return;
            end
            e = expected_ids.pop_front();
            if (word !== e.word)
            begin
                $error("id_word: expected %h, actual %h", e.word, word);
                errors++;
            end
            if (count !== e.count)
            begin
                $error("byte_count: expected %0d, actual %0d", e.count, count);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %b, actual %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   stall_left;

    id_model ids;

    rig_cfg_if cfg_ch();
    rig_req_if req_ch();
    rig_rsp_if rsp_ch();

    random_id_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [8:0] pick_nano_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 9'd0;
        else if (r < 70)
            return 9'($urandom_range(1, 24));
        else if (r < 88)
            return 9'($urandom_range(25, 64));
        else if (r < 94)
            return 9'($urandom_range(65, 255));
        else if (r < 97)
            return 9'd256;
        else
            return 9'($urandom_range(257, 511));
    endfunction

    // result side: random backpressure, long stalls now and then
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (quiet || $urandom_range(0, 99) < 70)
            rsp_ch.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 85)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(7, 39);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            ids.check_result(rsp_ch.id_word, rsp_ch.byte_count, rsp_ch.last);
    end

    task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        ids.store_seed(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high into the next request when no gap is drawn
    task automatic send_request(input logic [1:0] op, input logic [8:0] len);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.nano_length <= len;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        ids.note_request(op, len);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (ids.expected_ids.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int         sent;
        int         r;
        logic [1:0] op;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
                op = OP_UUID;
            else if (r < 60)
                op = OP_SHORT;
            else if (r < 95)
                op = OP_NANO;
            else
                op = OP_NONE;
            send_request(op, pick_nano_length());
            if (op != OP_NONE)
                sent++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        ids                = new();
        quiet              = 1'b0;
        stall_left         = 0;
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_SEED_A;
        cfg_ch.data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_NONE;
        req_ch.nano_length = '0;
        rsp_ch.ready       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the unused opcode must not load the generator from the seeds
        write_seed(CFG_SEED_A, pick_seed());
        write_seed(CFG_SEED_B, pick_seed());
        send_request(OP_NONE, 9'h1ff);
        drain();
        write_seed(CFG_SEED_A, pick_seed());
        write_seed(CFG_SEED_B, pick_seed());

        send_request(OP_UUID, 9'd0);
        send_request(OP_SHORT, 9'h1ff);
        send_request(OP_NANO, 9'd0);
        send_request(OP_NANO, 9'd1);
        send_request(OP_NANO, 9'd7);
        send_request(OP_NANO, 9'd8);
        send_request(OP_NANO, 9'd9);
        send_request(OP_NANO, 9'd16);
        send_request(OP_NANO, 9'd256);
        send_request(OP_NANO, 9'd257);
        send_request(OP_NANO, 9'h1ff);
        send_request(OP_NONE, 9'd5);
        send_request(OP_SHORT, 9'd0);
        send_request(OP_SHORT, 9'd3);
        send_request(OP_UUID, 9'h1ff);
        send_request(OP_NANO, 9'd2);
        send_request(OP_UUID, 9'd21);
        drain();

        // seeds written after loading are kept but have no effect
        write_seed(CFG_SEED_A, '0);
        write_seed(CFG_SEED_B, '1);
        send_random(RANDOM_REQUESTS / 3);
        drain();
        write_seed(CFG_SEED_A, '1);
        write_seed(CFG_SEED_B, '0);
        send_random(RANDOM_REQUESTS / 3);
        drain();
        write_seed(CFG_SEED_A, {$urandom, $urandom});
        write_seed(CFG_SEED_B, {$urandom, $urandom});
        send_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
        drain();

        if (ids.expected_ids.size() != 0)
        begin
            $error("%0d expected results never arrived", ids.expected_ids.size());
            ids.errors++;
        end
        if (ids.errors == 0)
            $display("random_id_generator_test: PASS");
        else
            $display("random_id_generator_test: FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("random_id_generator_test: FAIL");
        $finish;
    end

endmodule
